>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds whenever trig holds, outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed");

// Check that cond holds on every clock outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    `ASSERT_IMPLIES(label, clk, rst_n, 1'b1, cond)

`endif

>>> hw/rtl/crlf_pkg.sv
`timescale 1ns / 1ps

package crlf_pkg;

    localparam int BUF_DEPTH_DEF = 256;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CMD_LEAD   = 8'h01;
    localparam logic [7:0] CMD_TAG    = 8'h10;
    localparam logic [7:0] CMD_ANCHOR = 8'h11;

    localparam logic OP_RX   = 1'b0;
    localparam logic OP_ECHO = 1'b1;

    localparam logic [3:0] EV_NONE    = 4'd0;
    localparam logic [3:0] EV_STORED  = 4'd1;
    localparam logic [3:0] EV_CR      = 4'd2;
    localparam logic [3:0] EV_READY   = 4'd3;
    localparam logic [3:0] EV_TAG     = 4'd4;
    localparam logic [3:0] EV_ANCHOR  = 4'd5;
    localparam logic [3:0] EV_RESTART = 4'd6;
    localparam logic [3:0] EV_WRAP    = 4'd7;
    localparam logic [3:0] EV_ECHO    = 4'd8;
    localparam logic [3:0] EV_EMPTY   = 4'd9;
    localparam logic [3:0] EV_IGNORED = 4'd10;

    localparam logic MODE_TAG    = 1'b0;
    localparam logic MODE_ANCHOR = 1'b1;

    typedef struct packed {
        logic [3:0] event_res;
        logic [7:0] tx_byte;
        logic       tx_last;
        logic [7:0] line_length;
        logic       mode_select;
    } t_result;

endpackage

>>> hw/rtl/crlf_ram.sv
`timescale 1ns / 1ps

module crlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/crlf_front.sv
`timescale 1ns / 1ps

module crlf_front #(
    parameter int BUF_DEPTH = crlf_pkg::BUF_DEPTH_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic                                     i_op,
    input  logic [7:0]                               i_rx_byte,
    input  logic [$clog2(crlf_pkg::QUEUE_DEPTH+1)-1:0] i_q_level,
    output logic                                     o_push,
    output crlf_pkg::t_result                        o_push_data
);

    localparam int CW = $clog2(BUF_DEPTH);
    localparam int LW = $clog2(crlf_pkg::QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(BUF_DEPTH - 1);

    logic          r_complete, n_complete;
    logic          r_cr, n_cr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_echo, n_echo;
    logic [7:0]    r_b0, n_b0;
    logic [7:0]    r_b1, n_b1;

    logic              r_s1_valid;
    logic              r_s1_echo;
    crlf_pkg::t_result r_s1_res;

    logic              w_accept;
    logic              w_wr_en;
    logic              w_rd_en;
    logic [7:0]        w_rd_data;
    logic [LW:0]       w_used;
    logic [CW+7:0]     w_len_ext;
    crlf_pkg::t_result w_res;

    assign w_used   = {1'b0, i_q_level} + {{LW{1'b0}}, r_s1_valid};
    assign o_stall  = (w_used >= (LW+1)'(crlf_pkg::QUEUE_DEPTH));
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_complete        = r_complete;
        n_cr              = r_cr;
        n_cnt             = r_cnt;
        n_echo            = r_echo;
        n_b0              = r_b0;
        n_b1              = r_b1;
        w_wr_en           = 1'b0;
        w_rd_en           = 1'b0;
        w_res.event_res   = crlf_pkg::EV_NONE;
        w_res.tx_byte     = 8'd0;
        w_res.tx_last     = 1'b0;
        w_res.mode_select = crlf_pkg::MODE_TAG;
        if (i_op == crlf_pkg::OP_RX) begin
            if (r_complete) begin
                w_res.event_res = crlf_pkg::EV_IGNORED;
            end else if (r_cr) begin
                if (i_rx_byte != crlf_pkg::CH_LF) begin
                    n_cr            = 1'b0;
                    n_cnt           = '0;
                    n_echo          = '0;
                    w_res.event_res = crlf_pkg::EV_RESTART;
                end else if (r_b0 == crlf_pkg::CMD_LEAD && r_b1 == crlf_pkg::CMD_TAG) begin
                    n_cr            = 1'b0;
                    n_cnt           = '0;
                    n_echo          = '0;
                    w_res.event_res = crlf_pkg::EV_TAG;
                end else if (r_b0 == crlf_pkg::CMD_LEAD
                             && r_b1 == crlf_pkg::CMD_ANCHOR) begin
                    n_cr              = 1'b0;
                    n_cnt             = '0;
                    n_echo            = '0;
                    w_res.event_res   = crlf_pkg::EV_ANCHOR;
                    w_res.mode_select = crlf_pkg::MODE_ANCHOR;
                end else begin
                    n_complete      = 1'b1;
                    w_res.event_res = crlf_pkg::EV_READY;
                end
            end else if (i_rx_byte == crlf_pkg::CH_CR) begin
                n_cr            = 1'b1;
                w_res.event_res = crlf_pkg::EV_CR;
            end else begin
                w_wr_en = 1'b1;
                if (r_cnt == '0) begin
                    n_b0 = i_rx_byte;
                end
                if (r_cnt == CW'(1)) begin
                    n_b1 = i_rx_byte;
                end
                if (r_cnt == CNT_MAX) begin
                    n_cnt           = '0;
                    w_res.event_res = crlf_pkg::EV_WRAP;
                end else begin
                    n_cnt           = r_cnt + CW'(1);
                    w_res.event_res = crlf_pkg::EV_STORED;
                end
            end
        end else begin
            if (!r_complete) begin
                w_res.event_res = crlf_pkg::EV_NONE;
            end else if (r_cnt == '0) begin
                n_complete      = 1'b0;
                n_cr            = 1'b0;
                n_echo          = '0;
                w_res.event_res = crlf_pkg::EV_EMPTY;
            end else begin
                w_rd_en         = 1'b1;
                w_res.event_res = crlf_pkg::EV_ECHO;
                if (r_echo == r_cnt - CW'(1)) begin
                    w_res.tx_last = 1'b1;
                    n_complete    = 1'b0;
                    n_cr          = 1'b0;
                    n_cnt         = '0;
                    n_echo        = '0;
                end else begin
                    n_echo = r_echo + CW'(1);
                end
            end
        end
        w_len_ext         = {8'd0, n_cnt};
        w_res.line_length = w_len_ext[7:0];
    end

    crlf_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && w_wr_en),
        .i_wr_addr (r_cnt),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (w_accept && w_rd_en),
        .i_rd_addr (r_echo),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_complete <= 1'b0;
            r_cr       <= 1'b0;
            r_cnt      <= '0;
            r_echo     <= '0;
            r_b0       <= 8'd0;
            r_b1       <= 8'd0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            if (w_accept) begin
                r_complete <= n_complete;
                r_cr       <= n_cr;
                r_cnt      <= n_cnt;
                r_echo     <= n_echo;
                r_b0       <= n_b0;
                r_b1       <= n_b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_res  <= w_res;
            r_s1_echo <= w_rd_en;
        end
    end

    always_comb begin
        o_push_data = r_s1_res;
        if (r_s1_echo) begin
            o_push_data.tx_byte = w_rd_data;
        end
    end

    assign o_push = r_s1_valid;

endmodule

>>> hw/rtl/crlf_queue.sv
`timescale 1ns / 1ps

module crlf_queue (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_push,
    input  crlf_pkg::t_result                          i_push_data,
    input  logic                                       i_pop,
    output crlf_pkg::t_result                          o_head,
    output logic [$clog2(crlf_pkg::QUEUE_DEPTH+1)-1:0] o_level
);

    localparam int QD = crlf_pkg::QUEUE_DEPTH;
    localparam int AW = $clog2(QD);
    localparam int LW = $clog2(QD + 1);

    crlf_pkg::t_result r_mem [QD];
    logic [AW-1:0]     r_wp;
    logic [AW-1:0]     r_rp;
    logic [LW-1:0]     r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + LW'(1);
            end else if (!i_push && i_pop) begin
                r_level <= r_level - LW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_level = r_level;

endmodule

>>> hw/rtl/crlf_back.sv
`timescale 1ns / 1ps

module crlf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_nonempty,
    input  crlf_pkg::t_result i_q_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output crlf_pkg::t_result o_res
);

    logic              r_valid;
    crlf_pkg::t_result r_res;

    assign o_pop = i_q_nonempty && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= o_pop || (r_valid && i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_q_head;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> hw/rtl/crlf_line_receiver_echo.sv
//  channel  dir  handshake                 payload
//  in       in   i_in_valid / o_in_stall   i_op, i_rx_byte
//  out      out  o_out_valid / i_out_stall o_event_res, o_tx_byte, o_tx_last,
//                                          o_line_length, o_mode_select
//
//  One item per cycle unless stalled, one result per item, registered and queued.
//  The buffer RAM takes one write and one registered read per cycle.
//  Synchronous active-low reset clears the line state; no clearing pass runs,
//  since only buffer positions 0 and 1 can be read before being written and
//  they live in reset flops.
//  o_in_stall rises when the queue level plus the in-flight result reach QUEUE_DEPTH.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crlf_line_receiver_echo #(
    parameter int BUF_DEPTH = crlf_pkg::BUF_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_op,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [3:0] o_event_res,
    output logic [7:0] o_tx_byte,
    output logic       o_tx_last,
    output logic [7:0] o_line_length,
    output logic       o_mode_select
);

    localparam int LW = $clog2(crlf_pkg::QUEUE_DEPTH + 1);

    logic              w_push;
    logic              w_pop;
    crlf_pkg::t_result w_push_data;
    crlf_pkg::t_result w_head;
    crlf_pkg::t_result w_res;
    logic [LW-1:0]     w_level;

    crlf_front #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_op        (i_op),
        .i_rx_byte   (i_rx_byte),
        .i_q_level   (w_level),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    crlf_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_level     (w_level)
    );

    crlf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (w_level != '0),
        .i_q_head     (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_res        (w_res)
    );

    assign o_event_res   = w_res.event_res;
    assign o_tx_byte     = w_res.tx_byte;
    assign o_tx_last     = w_res.tx_last;
    assign o_line_length = w_res.line_length;
    assign o_mode_select = w_res.mode_select;

    `ASSERT_ALWAYS(a_level_bound, i_clk, i_rst_n,
        w_level <= LW'(crlf_pkg::QUEUE_DEPTH))
    `ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, w_push && !w_pop,
        w_level < LW'(crlf_pkg::QUEUE_DEPTH))
    `ASSERT_IMPLIES(a_last_is_echo, i_clk, i_rst_n, o_out_valid && o_tx_last,
        o_event_res == crlf_pkg::EV_ECHO && o_line_length == 8'd0)
    `ASSERT_IMPLIES(a_mode_clears, i_clk, i_rst_n,
        o_out_valid && (o_event_res == crlf_pkg::EV_TAG
                        || o_event_res == crlf_pkg::EV_ANCHOR),
        o_line_length == 8'd0)

endmodule

>>> dv/crlf_line_receiver_echo_tb.sv
`timescale 1ns / 1ps

module crlf_line_receiver_echo_tb;

    localparam int LINE_DEPTH     = crlf_pkg::BUF_DEPTH_DEF;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 20000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic       i_op;
    logic [7:0] i_rx_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [3:0] o_event_res;
    logic [7:0] o_tx_byte;
    logic       o_tx_last;
    logic [7:0] o_line_length;
    logic       o_mode_select;

    bit         held_line;
    bit         cr_pending;
    int         line_count;
    int         echo_pos;
    logic [7:0] line_mem [LINE_DEPTH];

    crlf_pkg::t_result expected_events[$];
    crlf_pkg::t_result want_res;
    int         errors;
    int         items_sent;
    int         idle_cycles;
    int         hold_cycles;
    int         send_idle_pct;
    int         stall_pct;

    crlf_line_receiver_echo i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_event_res  (o_event_res),
        .o_tx_byte    (o_tx_byte),
        .o_tx_last    (o_tx_last),
        .o_line_length(o_line_length),
        .o_mode_select(o_mode_select)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void clear_line();
        held_line  = 1'b0;
        cr_pending = 1'b0;
        line_count = 0;
        echo_pos   = 0;
    endfunction

    function automatic crlf_pkg::t_result advance_line_state(logic op, logic [7:0] data);
        crlf_pkg::t_result r;
        r = '0;
        r.event_res = crlf_pkg::EV_NONE;
        if (op == crlf_pkg::OP_RX) begin
            if (held_line) begin
                r.event_res = crlf_pkg::EV_IGNORED;
            end else if (cr_pending) begin
                if (data != crlf_pkg::CH_LF) begin
                    clear_line();
                    r.event_res = crlf_pkg::EV_RESTART;
                end else begin
                    held_line   = 1'b1;
                    r.event_res = crlf_pkg::EV_READY;
                    if (line_mem[0] == crlf_pkg::CMD_LEAD
                        && line_mem[1] == crlf_pkg::CMD_TAG) begin
                        clear_line();
                        r.event_res   = crlf_pkg::EV_TAG;
                        r.mode_select = crlf_pkg::MODE_TAG;
                    end else if (line_mem[0] == crlf_pkg::CMD_LEAD
                                 && line_mem[1] == crlf_pkg::CMD_ANCHOR) begin
                        clear_line();
                        r.event_res   = crlf_pkg::EV_ANCHOR;
                        r.mode_select = crlf_pkg::MODE_ANCHOR;
                    end
                end
            end else if (data == crlf_pkg::CH_CR) begin
                cr_pending  = 1'b1;
                r.event_res = crlf_pkg::EV_CR;
            end else begin
                line_mem[line_count] = data;
                line_count++;
                if (line_count >= LINE_DEPTH) begin
                    line_count  = 0;
                    r.event_res = crlf_pkg::EV_WRAP;
                end else begin
                    r.event_res = crlf_pkg::EV_STORED;
                end
            end
        end else begin
            if (!held_line) begin
                r.event_res = crlf_pkg::EV_NONE;
            end else if (line_count == 0) begin
                clear_line();
                r.event_res = crlf_pkg::EV_EMPTY;
            end else begin
                r.tx_byte = line_mem[echo_pos];
                echo_pos++;
                r.event_res = crlf_pkg::EV_ECHO;
                if (echo_pos >= line_count) begin
                    r.tx_last = 1'b1;
                    clear_line();
                end
            end
        end
        r.line_length = line_count[7:0];
        return r;
    endfunction

    task automatic send_item(logic op, logic [7:0] data);
        crlf_pkg::t_result want;
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_rx_byte  <= data;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        want = advance_line_state(op, data);
        expected_events.push_back(want);
        if (want.event_res != crlf_pkg::EV_IGNORED) items_sent++;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_text(int len);
        logic [7:0] b;
        repeat (len) begin
            b = 8'($urandom_range(255));
            if (b == crlf_pkg::CH_CR) b = crlf_pkg::CH_LF;
            send_item(crlf_pkg::OP_RX, b);
        end
    endtask

    task automatic finish_line();
        send_item(crlf_pkg::OP_RX, crlf_pkg::CH_CR);
        send_item(crlf_pkg::OP_RX, crlf_pkg::CH_LF);
    endtask

    task automatic echo_held_line();
        while (held_line) send_item(crlf_pkg::OP_ECHO, 8'($urandom_range(255)));
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic report_mismatch(string field, logic [7:0] want, logic [7:0] got);
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endtask

    task automatic test_directed();
        send_item(crlf_pkg::OP_ECHO, 8'hFF);
        finish_line();
        send_item(crlf_pkg::OP_ECHO, 8'h00);
        send_item(crlf_pkg::OP_RX, 8'hFF);
        send_item(crlf_pkg::OP_RX, 8'h00);
        finish_line();
        send_item(crlf_pkg::OP_RX, 8'h55);
        echo_held_line();
        send_item(crlf_pkg::OP_RX, crlf_pkg::CH_CR);
        send_item(crlf_pkg::OP_RX, 8'h41);
        send_item(crlf_pkg::OP_RX, crlf_pkg::CMD_LEAD);
        send_item(crlf_pkg::OP_RX, crlf_pkg::CMD_TAG);
        finish_line();
        // empty line decoded from stale buffer bytes
        finish_line();
        send_item(crlf_pkg::OP_RX, crlf_pkg::CMD_LEAD);
        send_item(crlf_pkg::OP_RX, crlf_pkg::CMD_ANCHOR);
        finish_line();
        send_item(crlf_pkg::OP_RX, crlf_pkg::CMD_LEAD);
        send_item(crlf_pkg::OP_RX, 8'h22);
        finish_line();
        echo_held_line();
    endtask

    task automatic test_wrap();
        send_text(LINE_DEPTH);
        finish_line();
        echo_held_line();
        send_text(LINE_DEPTH + 3);
        finish_line();
        echo_held_line();
    endtask

    task automatic test_output_hold();
        hold_cycles = 300;
        send_text(30);
        finish_line();
        echo_held_line();
        wait_for_results();
        send_text(5);
        finish_line();
        echo_held_line();
    endtask

    task automatic test_random(int count);
        int         start;
        int         kind;
        int         sel;
        int         len;
        logic [7:0] b;
        start = items_sent;
        while (items_sent - start < count) begin
            kind = $urandom_range(99);
            if (kind < 10) begin
                send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
            end else if (kind < 15) begin
                send_text($urandom_range(5));
                send_item(crlf_pkg::OP_RX, crlf_pkg::CH_CR);
                b = 8'($urandom_range(255));
                if (b == crlf_pkg::CH_LF) b = 8'h00;
                send_item(crlf_pkg::OP_RX, b);
            end else if (kind < 30) begin
                send_item(crlf_pkg::OP_RX, crlf_pkg::CMD_LEAD);
                sel = $urandom_range(2);
                if (sel == 0) send_item(crlf_pkg::OP_RX, crlf_pkg::CMD_TAG);
                else if (sel == 1) send_item(crlf_pkg::OP_RX, crlf_pkg::CMD_ANCHOR);
                else send_text(1);
                send_text($urandom_range(3));
                finish_line();
                echo_held_line();
            end else begin
                len = ($urandom_range(39) == 0) ? $urandom_range(250, 300) : $urandom_range(12);
                send_text(len);
                finish_line();
                if (held_line && $urandom_range(3) == 0) send_text($urandom_range(1, 3));
                echo_held_line();
                if ($urandom_range(4) == 0) send_item(crlf_pkg::OP_ECHO, 8'($urandom_range(255)));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles--;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_events.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, event %0d", $time, o_event_res);
            end else begin
                want_res = expected_events.pop_front();
                if (o_event_res !== want_res.event_res)
                    report_mismatch("event_res", 8'(want_res.event_res), 8'(o_event_res));
                if (o_tx_byte !== want_res.tx_byte)
                    report_mismatch("tx_byte", want_res.tx_byte, o_tx_byte);
                if (o_tx_last !== want_res.tx_last)
                    report_mismatch("tx_last", 8'(want_res.tx_last), 8'(o_tx_last));
                if (o_line_length !== want_res.line_length)
                    report_mismatch("line_length", want_res.line_length, o_line_length);
                if (o_mode_select !== want_res.mode_select)
                    report_mismatch("mode_select", 8'(want_res.mode_select),
                                    8'(o_mode_select));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        errors        = 0;
        items_sent    = 0;
        hold_cycles   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        clear_line();
        foreach (line_mem[i]) line_mem[i] = 8'h00;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_op        <= crlf_pkg::OP_RX;
        i_rx_byte   <= 8'h00;
        i_out_stall <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_wrap();
        test_output_hold();

        test_random(250);
        send_idle_pct = 55;
        test_random(250);
        send_idle_pct = 0;
        stall_pct     = 55;
        test_random(250);
        send_idle_pct = 20;
        stall_pct     = 20;
        test_random(250);

        wait_for_results();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
